// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scp_checker: property failed");

// Checks that the consequent holds when the item's result comes out.
`define SCP_ASSERT_LAT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (ante) |-> ##(scp_pkg::LAT) (cons)) \
    else $error("scp_checker: latency property failed");

`endif

// File: src/scp_pkg.sv
package scp_pkg;

  localparam logic signed [43:0] HALF_PI = 44'sh1921FB54443;
  localparam logic signed [43:0] PI      = 44'sh3243F6A8886;
  localparam logic signed [43:0] TWO_PI  = 44'sh6487ED5110C;
  localparam logic [51:0]        TWO_PI_U = 52'h6487ED5110C;

  localparam logic signed [36:0] Q30_ONE = 37'sd1073741824;
  localparam logic signed [32:0] K3 = 33'sd178956971;
  localparam logic signed [32:0] K5 = 33'sd8947849;
  localparam logic signed [32:0] K7 = 33'sd213044;
  localparam logic signed [32:0] K9 = 33'sd2959;

  localparam int RED   = 9;
  localparam int STEPS = 4;
  localparam int LAT   = 27;

  function automatic logic signed [32:0] horner_coef(input logic [1:0] step);
    logic signed [32:0] c;
    unique case (step)
      2'd0: c = -K7;
      2'd1: c = K5;
      2'd2: c = -K3;
      default: c = 33'(Q30_ONE);
    endcase
    return c;
  endfunction

  // Round to nearest at 2^-30, ties toward plus infinity.
  function automatic logic signed [36:0] round30(input logic signed [66:0] v);
    logic signed [66:0] w;
    w = v + 67'sd536870912;
    return 37'(w >>> 30);
  endfunction

endpackage

// File: src/sine_cosine_polynomial_top.sv
// strobe is the accepted start bit carried down the vld shift register beside the item's data, marking its result.
// Throughput: one item per cycle; range reduction is nine compare and subtract
// stages, and the polynomial is a chain of multiply stages, each followed by a round stage.
// busy is high only while rst is high; the receiver cannot stall the pipeline.
// Synchronous reset clears the valid bits; no result comes out of a flushed item.
module sine_cosine_polynomial_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               command,
  input  logic signed [31:0] angle,
  output logic               busy,
  output logic               strobe,
  output logic signed [31:0] value
);

  logic [scp_pkg::LAT-1:0] vld;

  logic signed [52:0] xa;
  logic [51:0]        red_mag [0:scp_pkg::RED];
  logic               red_neg [0:scp_pkg::RED];
  logic signed [43:0] ctr;
  logic               ctr_neg;
  logic signed [43:0] sgn;
  logic signed [43:0] fld;
  logic signed [31:0] q;
  logic signed [63:0] sq;
  logic signed [31:0] qd [0:9];
  logic signed [33:0] x2d [0:6];
  logic signed [66:0] hprod [0:scp_pkg::STEPS-1];
  logic signed [32:0] ht [0:scp_pkg::STEPS-1];
  logic signed [64:0] fprod;
  logic signed [36:0] fr;
  logic signed [43:0] sum512;

  assign busy = rst;
  assign strobe = vld[scp_pkg::LAT-1];
  assign fr = scp_pkg::round30(67'(fprod));
  assign sum512 = fld + 44'sd512;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[scp_pkg::LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    xa <= signed'({angle[31], angle, 20'd0}) +
          (command ? 53'(scp_pkg::HALF_PI) : 53'sd0);

    red_neg[0] <= xa[52];
    red_mag[0] <= xa[52] ? 52'(-xa) : 52'(xa);

    for (int i = 0; i < scp_pkg::RED; i++) begin
      if (red_mag[i] >= (scp_pkg::TWO_PI_U << (scp_pkg::RED - 1 - i))) begin
        red_mag[i+1] <= red_mag[i] - (scp_pkg::TWO_PI_U << (scp_pkg::RED - 1 - i));
      end else begin
        red_mag[i+1] <= red_mag[i];
      end
      red_neg[i+1] <= red_neg[i];
    end

    if (signed'(44'(red_mag[scp_pkg::RED])) > scp_pkg::PI) begin
      ctr <= signed'(44'(red_mag[scp_pkg::RED])) - scp_pkg::TWO_PI;
    end else begin
      ctr <= signed'(44'(red_mag[scp_pkg::RED]));
    end
    ctr_neg <= red_neg[scp_pkg::RED];

    sgn <= ctr_neg ? -ctr : ctr;

    if (sgn > scp_pkg::HALF_PI) begin
      fld <= scp_pkg::PI - sgn;
    end else if (sgn < -scp_pkg::HALF_PI) begin
      fld <= -scp_pkg::PI - sgn;
    end else begin
      fld <= sgn;
    end

    q <= 32'(sum512 >>> 10);

    sq <= 64'(q) * 64'(q);
    qd[0] <= q;
    for (int k = 1; k < 10; k++) begin
      qd[k] <= qd[k-1];
    end

    x2d[0] <= 34'(scp_pkg::round30(67'(sq)));
    for (int k = 1; k < 7; k++) begin
      x2d[k] <= x2d[k-1];
    end

    hprod[0] <= 67'(x2d[0]) * 67'(scp_pkg::K9);
    for (int n = 1; n < scp_pkg::STEPS; n++) begin
      hprod[n] <= 67'(x2d[2*n]) * 67'(ht[n-1]);
    end
    for (int n = 0; n < scp_pkg::STEPS; n++) begin
      ht[n] <= scp_pkg::horner_coef(2'(n)) + 33'(scp_pkg::round30(hprod[n]));
    end

    fprod <= 65'(qd[9]) * 65'(ht[scp_pkg::STEPS-1]);

    if (fr > scp_pkg::Q30_ONE) begin
      value <= 32'(scp_pkg::Q30_ONE);
    end else if (fr < -scp_pkg::Q30_ONE) begin
      value <= 32'(-scp_pkg::Q30_ONE);
    end else begin
      value <= 32'(fr);
    end
  end

endmodule

// File: src/scp_checker.sv
`include "assert_macros.svh"

module scp_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               command,
  input logic signed [31:0] angle,
  input logic               busy,
  input logic               strobe,
  input logic signed [31:0] value
);

  `SCP_ASSERT_IMP(a_value_range, strobe, (value <= 32'sd1073741824) && (value >= -32'sd1073741824))
  `SCP_ASSERT_LAT(a_latency, start && !busy, strobe)
  `SCP_ASSERT_LAT(a_sine_zero, start && !busy && !command && (angle == 32'sd0), value == 32'sd0)
  `SCP_ASSERT_LAT(a_cosine_zero, start && !busy && command && (angle == 32'sd0), value == 32'sd1073741824)

endmodule

bind sine_cosine_polynomial_top scp_checker u_scp_checker (.*);
